>>> src/pawc_pkg.sv
// Shared types and codes for the port activity window counter.
package pawc_pkg;

  localparam int PORT_BITS_DEF      = 10;
  localparam int BUCKET_COUNT_DEF   = 64;
  localparam int WINDOW_BUCKETS_DEF = 50;

  localparam int FUNC_W  = 3;
  localparam int BYTE_W  = 8;
  localparam int FRAME_W = 32;
  localparam int SUM_W   = 32;
  localparam int HIT_W   = 16;
  localparam int LOW_W   = 8;

  localparam logic [FUNC_W-1:0] FN_HIT       = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ADVANCE   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_RATE      = 3'd2;
  localparam logic [FUNC_W-1:0] FN_LAST      = 3'd3;
  localparam logic [FUNC_W-1:0] FN_RESET_ONE = 3'd4;
  localparam logic [FUNC_W-1:0] FN_RESET_ALL = 3'd5;

  // Byte address of the tracking enable register
  localparam logic REG_TRACK = 1'b0;

  localparam logic [HIT_W-1:0]   HIT_MAX   = 16'hFFFF;
  localparam logic [FRAME_W-1:0] FRAME_MAX = 32'hFFFF_FFFF;

  // Result of one item, handed from the engine to the output register
  typedef struct packed {
    logic [FRAME_W-1:0] age_frames;
    logic [BYTE_W-1:0]  last_value;
    logic               found;
    logic [SUM_W-1:0]   rate_sum;
  } res_t;

endpackage

>>> src/pawc_ram.sv
// Simple dual-port RAM with one write port and a registered read port.
module pawc_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/pawc_engine.sv
// Sequencer and shared accumulate/compare unit over the ring and port tables.
module pawc_engine #(
  parameter int PORT_BITS      = pawc_pkg::PORT_BITS_DEF,
  parameter int BUCKET_COUNT   = pawc_pkg::BUCKET_COUNT_DEF,
  parameter int WINDOW_BUCKETS = pawc_pkg::WINDOW_BUCKETS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pawc_pkg::FUNC_W-1:0]  in_func,
  input  logic [PORT_BITS-1:0]         in_port,
  input  logic                         in_aggregate,
  input  logic                         in_is_in,
  input  logic [pawc_pkg::BYTE_W-1:0]  in_data_value,
  input  logic [pawc_pkg::FRAME_W-1:0] in_frame,
  input  logic                         tracking_en,
  output logic                         res_valid,
  input  logic                         res_take,
  output pawc_pkg::res_t               res
);

  localparam int BKT_W   = $clog2(BUCKET_COUNT);
  localparam int RING_AW = PORT_BITS + BKT_W;
  localparam int HP      = 1 << (PORT_BITS - 8);
  localparam int HW      = (PORT_BITS > 8) ? PORT_BITS - 8 : 1;
  localparam int K_W     = $clog2(WINDOW_BUCKETS + 1);
  localparam int BW      = pawc_pkg::BYTE_W;
  localparam int FW      = pawc_pkg::FRAME_W;
  // Port entry layout, lowest bits first: pointer, read byte, read stamp,
  // write byte, write stamp
  localparam int RB_LO   = BKT_W;
  localparam int RS_LO   = RB_LO + BW;
  localparam int WB_LO   = RS_LO + FW;
  localparam int WS_LO   = WB_LO + BW;
  localparam int ENT_W   = WS_LO + FW;

  typedef enum logic [12:0] {
    ST_CLR     = 13'b0000000000001,
    ST_IDLE    = 13'b0000000000010,
    ST_PCLR    = 13'b0000000000100,
    ST_HIT_PTR = 13'b0000000001000,
    ST_HIT_UPD = 13'b0000000010000,
    ST_ADV_RD  = 13'b0000000100000,
    ST_ADV_WR  = 13'b0000001000000,
    ST_Q_RD    = 13'b0000010000000,
    ST_Q_PTR   = 13'b0000100000000,
    ST_Q_SUM   = 13'b0001000000000,
    ST_L_RD    = 13'b0010000000000,
    ST_L_CHK   = 13'b0100000000000,
    ST_DONE    = 13'b1000000000000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [pawc_pkg::FUNC_W-1:0]  op_r, op_nxt;
  logic [PORT_BITS-1:0]         port_r, port_nxt;
  logic                         agg_r, agg_nxt;
  logic                         isin_r, isin_nxt;
  logic [BW-1:0]                data_r, data_nxt;
  logic [FW-1:0]                frame_r, frame_nxt;
  logic [RING_AW-1:0]           cnt_r, cnt_nxt;
  logic [PORT_BITS-1:0]         adv_r, adv_nxt;
  logic [BKT_W-1:0]             bkt_r, bkt_nxt;
  logic [HW-1:0]                h_r, h_nxt;
  logic [BKT_W-1:0]             idx_r, idx_nxt;
  logic [K_W-1:0]               k_r, k_nxt;
  logic                         pend_r, pend_nxt;
  pawc_pkg::res_t               acc_r, acc_nxt;

  logic [PORT_BITS-1:0]         qport;
  logic                         last_part;
  logic                         rw_rd, rw_wr;
  logic [RING_AW-1:0]           r_waddr, r_raddr;
  logic [pawc_pkg::HIT_W-1:0]   r_wdata, rd_q, wr_q, ring_q;
  logic                         p_we;
  logic [PORT_BITS-1:0]         p_waddr, p_raddr;
  logic [ENT_W-1:0]             p_wdata, ent;
  logic [BKT_W-1:0]             ent_ptr, nb;
  logic [FW-1:0]                stamp, at, age;
  logic [FW-1:0]                new_stamp;

  function automatic logic [BKT_W-1:0] bkt_dec(input logic [BKT_W-1:0] b);
    bkt_dec = (b == '0) ? BKT_W'(BUCKET_COUNT - 1) : b - BKT_W'(1);
  endfunction

  pawc_ram #(.ADDR_W(RING_AW), .DATA_W(pawc_pkg::HIT_W)) u_ring_rd (
    .clk(clk), .we(rw_rd), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(rd_q)
  );

  pawc_ram #(.ADDR_W(RING_AW), .DATA_W(pawc_pkg::HIT_W)) u_ring_wr (
    .clk(clk), .we(rw_wr), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(wr_q)
  );

  pawc_ram #(.ADDR_W(PORT_BITS), .DATA_W(ENT_W)) u_port_tab (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(ent)
  );

  // Port of the current part for queries
  assign qport     = agg_r ? ((PORT_BITS'(h_r) << 8) | PORT_BITS'(port_r[7:0])) : port_r;
  assign last_part = !agg_r || (h_r == HW'(HP - 1));
  assign ent_ptr   = ent[BKT_W-1:0];
  assign nb        = (ent_ptr == BKT_W'(BUCKET_COUNT - 1)) ? '0 : ent_ptr + BKT_W'(1);
  assign ring_q    = isin_r ? rd_q : wr_q;
  assign stamp     = isin_r ? ent[RS_LO +: FW] : ent[WS_LO +: FW];
  assign at        = stamp - FW'(1);
  assign age       = (frame_r >= at) ? frame_r - at : '0;
  assign new_stamp = (frame_r == pawc_pkg::FRAME_MAX) ? pawc_pkg::FRAME_MAX
                                                       : frame_r + FW'(1);

  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res       = acc_r;

  // Sequencer and memory port control
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    port_nxt  = port_r;
    agg_nxt   = agg_r;
    isin_nxt  = isin_r;
    data_nxt  = data_r;
    frame_nxt = frame_r;
    cnt_nxt   = cnt_r;
    adv_nxt   = adv_r;
    bkt_nxt   = bkt_r;
    h_nxt     = h_r;
    idx_nxt   = idx_r;
    k_nxt     = k_r;
    pend_nxt  = 1'b0;
    acc_nxt   = acc_r;
    rw_rd     = 1'b0;
    rw_wr     = 1'b0;
    r_waddr   = {port_r, bkt_r};
    r_wdata   = '0;
    r_raddr   = {qport, idx_r};
    p_we      = 1'b0;
    p_waddr   = port_r;
    p_wdata   = '0;
    p_raddr   = qport;

    case (state_r)
      ST_CLR: begin
        // Sweep every ring entry; the port table is cleared along the way
        rw_rd   = 1'b1;
        rw_wr   = 1'b1;
        r_waddr = cnt_r;
        p_we    = 1'b1;
        p_waddr = cnt_r[RING_AW-1 -: PORT_BITS];
        cnt_nxt = cnt_r + RING_AW'(1);
        if (cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // Look up the entry of the offered port so a hit finds it next cycle
        p_raddr = in_port;
        if (in_valid) begin
          op_nxt    = in_func;
          port_nxt  = in_port;
          agg_nxt   = in_aggregate;
          isin_nxt  = in_is_in;
          data_nxt  = in_data_value;
          frame_nxt = in_frame;
          acc_nxt   = '0;
          bkt_nxt   = '0;
          h_nxt     = '0;
          adv_nxt   = '0;
          cnt_nxt   = '0;
          case (in_func)
            pawc_pkg::FN_HIT: begin
              agg_nxt   = 1'b0;
              state_nxt = ST_HIT_PTR;
            end
            pawc_pkg::FN_ADVANCE:   state_nxt = tracking_en ? ST_ADV_RD : ST_DONE;
            pawc_pkg::FN_RATE:      state_nxt = ST_Q_RD;
            pawc_pkg::FN_LAST:      state_nxt = ST_L_RD;
            pawc_pkg::FN_RESET_ONE: state_nxt = ST_PCLR;
            default:                state_nxt = ST_DONE;
          endcase
        end
      end
      ST_PCLR: begin
        // Clear one port's buckets in both rings and its table entry
        rw_rd   = 1'b1;
        rw_wr   = 1'b1;
        p_we    = 1'b1;
        bkt_nxt = bkt_r + BKT_W'(1);
        if (bkt_r == '1) begin
          state_nxt = ST_DONE;
        end
      end
      ST_HIT_PTR: begin
        // Entry is in; fetch the current bucket
        r_raddr   = {port_r, ent_ptr};
        state_nxt = ST_HIT_UPD;
      end
      ST_HIT_UPD: begin
        // Saturating increment and byte/stamp update
        r_waddr = {port_r, ent_ptr};
        r_wdata = (ring_q == pawc_pkg::HIT_MAX) ? ring_q
                                                 : ring_q + pawc_pkg::HIT_W'(1);
        rw_rd   = isin_r;
        rw_wr   = !isin_r;
        p_we    = 1'b1;
        p_wdata = ent;
        if (isin_r) begin
          p_wdata[RB_LO +: BW] = data_r;
          p_wdata[RS_LO +: FW] = new_stamp;
        end else begin
          p_wdata[WB_LO +: BW] = data_r;
          p_wdata[WS_LO +: FW] = new_stamp;
        end
        state_nxt = ST_DONE;
      end
      ST_ADV_RD: begin
        p_raddr   = adv_r;
        state_nxt = ST_ADV_WR;
      end
      ST_ADV_WR: begin
        // Move the pointer and clear the new bucket in both rings
        p_we                 = 1'b1;
        p_waddr              = adv_r;
        p_wdata              = ent;
        p_wdata[BKT_W-1:0]   = nb;
        rw_rd                = 1'b1;
        rw_wr                = 1'b1;
        r_waddr              = {adv_r, nb};
        adv_nxt              = adv_r + PORT_BITS'(1);
        state_nxt            = (adv_r == '1) ? ST_DONE : ST_ADV_RD;
      end
      ST_Q_RD: begin
        state_nxt = ST_Q_PTR;
      end
      ST_Q_PTR: begin
        idx_nxt   = bkt_dec(ent_ptr);
        k_nxt     = '0;
        state_nxt = ST_Q_SUM;
      end
      ST_Q_SUM: begin
        // Issue one bucket read a cycle, add the one that came back
        if (k_r != K_W'(WINDOW_BUCKETS)) begin
          pend_nxt = 1'b1;
          idx_nxt  = bkt_dec(idx_r);
          k_nxt    = k_r + K_W'(1);
        end
        if (pend_r) begin
          acc_nxt.rate_sum = acc_r.rate_sum + pawc_pkg::SUM_W'(ring_q);
        end
        if (k_r == K_W'(WINDOW_BUCKETS) && !pend_r) begin
          h_nxt     = h_r + HW'(1);
          state_nxt = last_part ? ST_DONE : ST_Q_RD;
        end
      end
      ST_L_RD: begin
        state_nxt = ST_L_CHK;
      end
      ST_L_CHK: begin
        // Keep the youngest value; earlier part wins a tie
        if (stamp != '0 && (!acc_r.found || age < acc_r.age_frames)) begin
          acc_nxt.found      = 1'b1;
          acc_nxt.age_frames = age;
          acc_nxt.last_value = isin_r ? ent[RB_LO +: BW] : ent[WB_LO +: BW];
        end
        h_nxt     = h_r + HW'(1);
        state_nxt = last_part ? ST_DONE : ST_L_RD;
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = (op_r == pawc_pkg::FN_RESET_ALL) ? ST_CLR : ST_IDLE;
        end
      end
      default: state_nxt = ST_CLR;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      op_r    <= pawc_pkg::FN_HIT;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      op_r    <= op_nxt;
    end
  end

  // Payload and work registers
  always_ff @(posedge clk) begin
    port_r  <= port_nxt;
    agg_r   <= agg_nxt;
    isin_r  <= isin_nxt;
    data_r  <= data_nxt;
    frame_r <= frame_nxt;
    adv_r   <= adv_nxt;
    bkt_r   <= bkt_nxt;
    h_r     <= h_nxt;
    idx_r   <= idx_nxt;
    k_r     <= k_nxt;
    acc_r   <= acc_nxt;
  end

endmodule

>>> src/port_activity_window_counter_core.sv
// Top level of the port activity window counter: stream ports, APB register, output register.
//
//  channel  direction  handshake              payload
//  in_      slave      in_tvalid / in_tready  func, port, aggregate, is_in, data_value, frame
//  out_     master     out_tvalid / out_tready rate_sum, found, last_value, age_frames
//  cfg_     APB slave  psel / penable / pready register 0: tracking_enable
//
// One item at a time. Frame advance does one port table read and write per port.
// Rate query does one ring read per cycle over WINDOW_BUCKETS buckets per part; parts is
// 2**(PORT_BITS-8) with aggregate, else 1. Last-value query reads one entry per part.
// After reset and after reset-all a clearing pass over every ring entry runs with
// in_tready low. A waiting result holds the engine until it is taken.
module port_activity_window_counter_core #(
  parameter int PORT_BITS      = pawc_pkg::PORT_BITS_DEF,
  parameter int BUCKET_COUNT   = pawc_pkg::BUCKET_COUNT_DEF,
  parameter int WINDOW_BUCKETS = pawc_pkg::WINDOW_BUCKETS_DEF,
  localparam int IN_BITS  = pawc_pkg::FUNC_W + PORT_BITS + 2 + pawc_pkg::BYTE_W
                            + pawc_pkg::FRAME_W,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = $bits(pawc_pkg::res_t),
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // func, port, aggregate, is_in, data_value, frame
  input  logic [IN_W-1:0]       in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // rate_sum, found, last_value, age_frames
  output logic [OUT_W-1:0]      out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic                  cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int P_LO     = pawc_pkg::FUNC_W;
  localparam int A_LO     = P_LO + PORT_BITS;
  localparam int D_LO     = A_LO + 2;
  localparam int F_LO     = D_LO + pawc_pkg::BYTE_W;

  logic           track_r;
  logic           out_valid_r;
  pawc_pkg::res_t out_r;
  logic           res_valid, res_take;
  pawc_pkg::res_t res;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {31'b0, track_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == pawc_pkg::REG_TRACK) begin
      track_r <= cfg_pwdata[0];
    end
  end

  pawc_engine #(
    .PORT_BITS(PORT_BITS), .BUCKET_COUNT(BUCKET_COUNT), .WINDOW_BUCKETS(WINDOW_BUCKETS)
  ) u_engine (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .in_func(in_tdata[pawc_pkg::FUNC_W-1:0]),
    .in_port(in_tdata[P_LO +: PORT_BITS]),
    .in_aggregate(in_tdata[A_LO]),
    .in_is_in(in_tdata[A_LO+1]),
    .in_data_value(in_tdata[D_LO +: pawc_pkg::BYTE_W]),
    .in_frame(in_tdata[F_LO +: pawc_pkg::FRAME_W]),
    .tracking_en(track_r),
    .res_valid(res_valid),
    .res_take(res_take),
    .res(res)
  );

  // Output register: load when empty or being drained
  assign res_take = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_r);

  // An accepted item keeps the input closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input reopened right after a transfer");

  // A handed-over result shows up on the output
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_take) |=> out_tvalid)
    else $error("result lost on its way to the output register");

  // The clearing pass keeps the input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_tready)
    else $error("input open during the clearing pass");

  // No result is presented while a new item may enter
  a_no_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !res_valid)
    else $error("engine idle and done at once");

endmodule
